// ----- hdl/swfc_pkg.sv -----
// Shared types and constants for the single-wire fast-charge transmitter.
package swfc_pkg;

   // Line sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_LEAD_LOW  = 4'd1,
      PH_SYNC1_HI  = 4'd2,
      PH_SYNC1_LO  = 4'd3,
      PH_EXTRA_HI  = 4'd4,
      PH_BITS      = 4'd5,
      PH_PAR_LEVEL = 4'd6,
      PH_PAR_LOW   = 4'd7,
      PH_SYNC2_HI  = 4'd8,
      PH_SYNC2_LO  = 4'd9,
      PH_PING_HI   = 4'd10,
      PH_RESET_HI  = 4'd11
   } phase_type;

   // Command codes
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_PING  = 2'd1,
      CMD_DATA  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   // Register indexes (word address bits)
   localparam logic [1:0] CSR_UNIT  = 2'd0;
   localparam logic [1:0] CSR_SYNC  = 2'd1;
   localparam logic [1:0] CSR_PING  = 2'd2;
   localparam logic [1:0] CSR_RESET = 2'd3;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned TICK_WIDTH     = 16;

   // Register reset values
   localparam logic [TICK_WIDTH-1:0] UNIT_RESET  = 16'd160;
   localparam logic [TICK_WIDTH-1:0] SYNC_RESET  = 16'd40;
   localparam logic [TICK_WIDTH-1:0] PING_RESET  = 16'd2560;
   localparam logic [TICK_WIDTH-1:0] PULSE_RESET = 16'd16000;

   localparam logic [3:0] DATA_BITS = 4'd8;

endpackage

// ----- hdl/single_wire_fast_charge_tx_core.sv -----
// Single-wire fast-charge transmitter: line sequencer with APB register port.
// The result of a tick is registered and presented in the cycle after acceptance.
// Throughput: one tick per cycle; the phase counter and sequencer advance once per tick.
// A tick is taken whenever the result register is empty or being drained.
// Reset (synchronous, active high): sequencer idle, counters zero, registers at defaults.
module single_wire_fast_charge_tx_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick input channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_cmd,
   input  logic [7:0]                           req_data_byte,
   // line result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_line_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   // register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [swfc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [swfc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [swfc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import swfc_pkg::*;

   logic [TICK_WIDTH-1:0] unit_ff, sync_ff, ping_ff, pulse_ff;

   phase_type             phase_ff,  phase_in;
   logic [TICK_WIDTH-1:0] timer_ff,  timer_in;
   logic [7:0]            shift_ff,  shift_in;
   logic [3:0]            bits_ff,   bits_in;
   logic                  parity_ff, parity_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic level_ff, level_in;
   logic busy_ff,  busy_in;
   logic done_ff,  done_in;

   logic req_take;
   logic rsp_take;
   logic csr_write;
   logic [1:0] csr_index;

   // Ticks left minus one; a zero length acts as one tick
   function automatic logic [TICK_WIDTH-1:0] len_m1(input logic [TICK_WIDTH-1:0] len);
      return (len == '0) ? '0 : len - 1'b1;
   endfunction

   function automatic logic [TICK_WIDTH-1:0] phase_len_m1(
      input phase_type             ph,
      input logic [TICK_WIDTH-1:0] unit_len,
      input logic [TICK_WIDTH-1:0] sync_len,
      input logic [TICK_WIDTH-1:0] ping_len,
      input logic [TICK_WIDTH-1:0] pulse_len
   );
      logic [TICK_WIDTH-1:0] len;
      len = {{(TICK_WIDTH-1){1'b0}}, 1'b1};
      case (ph)
         PH_LEAD_LOW, PH_BITS, PH_PAR_LEVEL: len = unit_len;
         PH_SYNC1_HI, PH_SYNC1_LO, PH_EXTRA_HI,
         PH_PAR_LOW, PH_SYNC2_HI, PH_SYNC2_LO: len = sync_len;
         PH_PING_HI:  len = ping_len;
         PH_RESET_HI: len = pulse_len;
         default:     len = {{(TICK_WIDTH-1){1'b0}}, 1'b1};
      endcase
      return len_m1(len);
   endfunction

   // Handshakes
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];
   assign rsp_take   = rsp_valid_ff & ~rsp_stall;
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_take   = req_valid & ~req_stall;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff  <= UNIT_RESET;
         sync_ff  <= SYNC_RESET;
         ping_ff  <= PING_RESET;
         pulse_ff <= PULSE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_UNIT:  unit_ff  <= csr_pwdata[TICK_WIDTH-1:0];
            CSR_SYNC:  sync_ff  <= csr_pwdata[TICK_WIDTH-1:0];
            CSR_PING:  ping_ff  <= csr_pwdata[TICK_WIDTH-1:0];
            CSR_RESET: pulse_ff <= csr_pwdata[TICK_WIDTH-1:0];
            default:   ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         CSR_UNIT:  csr_prdata = {{(CSR_DATA_WIDTH-TICK_WIDTH){1'b0}}, unit_ff};
         CSR_SYNC:  csr_prdata = {{(CSR_DATA_WIDTH-TICK_WIDTH){1'b0}}, sync_ff};
         CSR_PING:  csr_prdata = {{(CSR_DATA_WIDTH-TICK_WIDTH){1'b0}}, ping_ff};
         CSR_RESET: csr_prdata = {{(CSR_DATA_WIDTH-TICK_WIDTH){1'b0}}, pulse_ff};
         default:   csr_prdata = '0;
      endcase
   end

   // Sequencer: one tick per transaction
   always_comb begin
      phase_type nx;
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      parity_in = parity_ff;
      level_in  = 1'b0;
      busy_in   = 1'b0;
      done_in   = 1'b0;
      nx        = PH_IDLE;

      // unknown codes fall back to idle
      if (phase_in > PH_RESET_HI) begin
         phase_in = PH_IDLE;
         timer_in = '0;
      end

      // start a sequence only from idle
      if (phase_in == PH_IDLE) begin
         case (req_cmd)
            CMD_PING: begin
               phase_in = PH_PING_HI;
            end
            CMD_DATA: begin
               shift_in  = req_data_byte;
               bits_in   = DATA_BITS;
               parity_in = ^req_data_byte;
               phase_in  = PH_LEAD_LOW;
            end
            CMD_RESET: begin
               phase_in = PH_RESET_HI;
            end
            default: ;
         endcase
         if (phase_in != PH_IDLE)
            timer_in = phase_len_m1(phase_in, unit_ff, sync_ff, ping_ff, pulse_ff);
      end

      if (phase_in != PH_IDLE) begin
         busy_in = 1'b1;
         // line level for this tick
         if (phase_in inside {PH_SYNC1_HI, PH_EXTRA_HI, PH_SYNC2_HI, PH_PING_HI,
                              PH_RESET_HI})
            level_in = 1'b1;
         else if (phase_in == PH_BITS)
            level_in = shift_in[7];
         else if (phase_in == PH_PAR_LEVEL)
            level_in = ~parity_in;

         if (timer_in == '0) begin
            // phase ends: pick the next one
            case (phase_in)
               PH_LEAD_LOW:  nx = PH_SYNC1_HI;
               PH_SYNC1_HI:  nx = PH_SYNC1_LO;
               PH_SYNC1_LO:  nx = shift_in[7] ? PH_BITS : PH_EXTRA_HI;
               PH_EXTRA_HI:  nx = PH_BITS;
               PH_BITS: begin
                  shift_in = {shift_in[6:0], 1'b0};
                  bits_in  = bits_in - 1'b1;
                  nx = (bits_in == '0) ? PH_PAR_LEVEL : PH_BITS;
               end
               PH_PAR_LEVEL: nx = parity_in ? PH_SYNC2_HI : PH_PAR_LOW;
               PH_PAR_LOW:   nx = PH_SYNC2_HI;
               PH_SYNC2_HI:  nx = PH_SYNC2_LO;
               PH_SYNC2_LO:  nx = PH_PING_HI;
               default:      nx = PH_IDLE;
            endcase
            phase_in = nx;
            timer_in = phase_len_m1(nx, unit_ff, sync_ff, ping_ff, pulse_ff);
            if (nx == PH_IDLE) begin
               timer_in = '0;
               done_in  = 1'b1;
            end
         end else begin
            timer_in = timer_in - 1'b1;
         end
      end
   end

   // Sequencer state advances on each accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         timer_ff  <= '0;
         shift_ff  <= '0;
         bits_ff   <= '0;
         parity_ff <= 1'b0;
      end else if (req_take) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
         parity_ff <= parity_in;
      end
   end

   // Result register
   assign rsp_valid_in = req_take | (rsp_valid_ff & ~rsp_take);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         level_ff <= level_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_line_level = level_ff;
   assign rsp_busy_res   = busy_ff;
   assign rsp_done_res   = done_ff;

endmodule

// ----- hdl/swfc_checker.sv -----
// Port-level checks for the single-wire fast-charge transmitter, bound to the top level.
module swfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_line_level,
   input logic rsp_busy_res,
   input logic rsp_done_res
);

   // last tick of a sequence is still a busy tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   // idle ticks keep the line low
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> !rsp_line_level)
      else $error("line high while idle");

   // input is held back only by a full, stalled result register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");

   // every accepted tick gives a result on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_level)
         && $stable(rsp_busy_res) && $stable(rsp_done_res))
      else $error("stalled result changed");

endmodule

bind single_wire_fast_charge_tx_core swfc_checker u_swfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_line_level (rsp_line_level),
   .rsp_busy_res   (rsp_busy_res),
   .rsp_done_res   (rsp_done_res)
);
